// ----- src/ttp_pkg.sv -----
// Shared types, codes and helpers of the task timing profiler.
`timescale 1ns / 1ps

package ttp_pkg;

   localparam logic [63:0] ALL_ONES = '1;

   typedef enum logic [1:0] {
      OP_RUN   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_SUM   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_SUM_END,
      ST_CALC,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic        enabled;
      logic [63:0] next_due;
      logic [63:0] prev_start;
      logic        seen;
      logic [31:0] count;
      logic [63:0] run_total;
      logic [63:0] run_min;
      logic [63:0] run_max;
      logic [63:0] per_min;
      logic [63:0] per_max;
   } rec_type;

   // Statistics as a clear leaves them, with the task enabled; schedule fields and seen flag survive.
   function automatic rec_type clear_rec(rec_type r);
      rec_type c;
      c           = r;
      c.enabled   = 1'b1;
      c.count     = '0;
      c.run_total = '0;
      c.run_min   = ALL_ONES;
      c.run_max   = '0;
      c.per_min   = ALL_ONES;
      c.per_max   = '0;
      return c;
   endfunction

endpackage

// ----- src/task_timing_profiler.sv -----
// Top level of the task timing profiler: sequencer, request capture, result register.
`timescale 1ns / 1ps
//
// Usage
//   Request channel (req_*): operation, task_id and four 64-bit timestamps.
//   An item is taken at a rising edge with req_valid high and req_stall low.
//   Result channel (rsp_*): one result item per request, taken at an edge
//   with rsp_valid high and rsp_stall low.
//   Timing: run, read and clear read their record at the accepting edge, then
//   pass one compare stage and one update and write-back stage, which loads
//   the result item into the output register. A sum first walks every record
//   through the single memory read port, one per cycle, then reads the
//   addressed record and passes the same compare and update stages. One item
//   is in work at a time; req_stall stays high from acceptance until the
//   result is loaded into the output register.
//   A new item can be taken while that result still waits on rsp_stall; its
//   write-back then holds until the output register is free.
//   Reset: all records read as zero and tasks are disabled; no clearing pass
//   is needed, per-entry flags stand in for the memory contents.
//   A clear only marks every record as cleared, so it takes as long as a read.
//
module task_timing_profiler #(
   parameter int NUM_TASKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [3:0]  req_task_id,
   input  logic [63:0] req_spacing_us,
   input  logic [63:0] req_loop_time_us,
   input  logic [63:0] req_start_time_us,
   input  logic [63:0] req_stop_time_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ran,
   output logic        rsp_frame_ok,
   output logic [31:0] rsp_out_starts,
   output logic [63:0] rsp_out_run_total,
   output logic [63:0] rsp_out_run_min,
   output logic [63:0] rsp_out_run_max,
   output logic [63:0] rsp_out_period_min,
   output logic [63:0] rsp_out_period_max,
   output logic [63:0] rsp_grand_total
);
   import ttp_pkg::*;

   localparam int          AW   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [AW-1:0] LAST = AW'(NUM_TASKS - 1);

   state_type   state_ff, state_in;
   op_type      op_ff;
   logic        id_ok_ff;
   logic [AW-1:0] addr_ff;
   logic [63:0] interval_ff, loop_ff, start_ff, stop_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic [63:0] acc_ff, acc_in;
   logic        sum_pend_ff, sum_pend_in;

   logic        accept;
   logic [8:0]  id_ext;
   logic [AW-1:0] req_addr;
   logic        req_id_ok;
   logic        rd_en;
   logic [AW-1:0] rd_addr;
   logic        calc_ld;
   logic        out_free;
   logic        commit_go;
   logic        clr_now;
   logic        ran, frame_ok;
   rec_type     rd_rec, new_rec;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ran_ff, rsp_frame_ok_ff;
   logic [31:0] rsp_count_ff;
   logic [63:0] rsp_total_ff, rsp_rmin_ff, rsp_rmax_ff, rsp_pmin_ff, rsp_pmax_ff;
   logic [63:0] rsp_grand_ff;

   // Request decode: ids at or beyond NUM_TASKS address no record.
   assign id_ext    = {5'b0, req_task_id};
   assign req_addr  = id_ext[AW-1:0];
   assign req_id_ok = id_ext < 9'(NUM_TASKS);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (op_type'(req_operation) == OP_SUM) ? ST_SUM : ST_CALC;
            end
         end
         ST_SUM: begin
            if (idx_ff == LAST) state_in = ST_SUM_END;
         end
         ST_SUM_END: state_in = ST_CALC;
         ST_CALC:    state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: memory read port, stage load, commit.
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      rd_addr   = addr_ff;
      calc_ld   = 1'b0;
      commit_go = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            rd_en     = accept;
            rd_addr   = req_addr;
         end
         ST_SUM: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff;
         end
         ST_SUM_END: begin
            // fetch the addressed record once the walk is done
            rd_en   = 1'b1;
            rd_addr = addr_ff;
         end
         ST_CALC:   calc_ld   = 1'b1;
         ST_COMMIT: commit_go = out_free;
         default:   req_stall = 1'b1;
      endcase
   end

   // Sum walk: index advance, and accumulation in the cycle after the read.
   always_comb begin
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      sum_pend_in = (state_ff == ST_SUM);
      if (state_ff == ST_IDLE) begin
         idx_in = '0;
         acc_in = '0;
      end else if (state_ff == ST_SUM) begin
         idx_in = AW'(idx_ff + 1'b1);
      end
      if (sum_pend_ff) begin
         acc_in = acc_ff + rd_rec.run_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sum_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sum_pend_ff <= sum_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      acc_ff <= acc_in;
   end

   // Hold the request for the whole operation.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= op_type'(req_operation);
         id_ok_ff    <= req_id_ok;
         addr_ff     <= req_addr;
         interval_ff <= req_spacing_us;
         loop_ff     <= req_loop_time_us;
         start_ff    <= req_start_time_us;
         stop_ff     <= req_stop_time_us;
      end
   end

   // A clear, or a sum that came to zero, marks every record as cleared.
   assign clr_now = (op_ff == OP_CLEAR) || ((op_ff == OP_SUM) && (acc_ff == '0));

   ttp_store #(
      .NUM_TASKS (NUM_TASKS),
      .AW        (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (commit_go && ran),
      .wr_addr (addr_ff),
      .wr_data (new_rec),
      .clr_all (commit_go && clr_now),
      .rd_rec  (rd_rec)
   );

   ttp_alu u_alu (
      .clock         (clock),
      .calc_ld       (calc_ld),
      .is_run        (op_ff == OP_RUN),
      .id_ok         (id_ok_ff),
      .clr_now       (clr_now),
      .rec           (rd_rec),
      .spacing_us    (interval_ff),
      .loop_time_us  (loop_ff),
      .start_time_us (start_ff),
      .stop_time_us  (stop_ff),
      .new_rec       (new_rec),
      .ran           (ran),
      .frame_ok      (frame_ok)
   );

   // Output register: load on commit, hold while the receiver stalls.
   assign rsp_valid_in = commit_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (commit_go) begin
         rsp_ran_ff      <= ran;
         rsp_frame_ok_ff <= frame_ok;
         rsp_count_ff    <= id_ok_ff ? new_rec.count     : '0;
         rsp_total_ff    <= id_ok_ff ? new_rec.run_total : '0;
         rsp_rmin_ff     <= id_ok_ff ? new_rec.run_min   : '0;
         rsp_rmax_ff     <= id_ok_ff ? new_rec.run_max   : '0;
         rsp_pmin_ff     <= id_ok_ff ? new_rec.per_min   : '0;
         rsp_pmax_ff     <= id_ok_ff ? new_rec.per_max   : '0;
         rsp_grand_ff    <= (op_ff != OP_SUM) ? '0 :
                            ((acc_ff == '0) ? ALL_ONES : acc_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ran             = rsp_ran_ff;
   assign rsp_frame_ok        = rsp_frame_ok_ff;
   assign rsp_out_starts      = rsp_count_ff;
   assign rsp_out_run_total   = rsp_total_ff;
   assign rsp_out_run_min     = rsp_rmin_ff;
   assign rsp_out_run_max     = rsp_rmax_ff;
   assign rsp_out_period_min  = rsp_pmin_ff;
   assign rsp_out_period_max  = rsp_pmax_ff;
   assign rsp_grand_total     = rsp_grand_ff;

endmodule

// ----- src/ttp_store.sv -----
// Record memory with written and cleared flags per entry.
`timescale 1ns / 1ps

module ttp_store #(
   parameter int NUM_TASKS = 16,
   parameter int AW        = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  ttp_pkg::rec_type wr_data,
   input  logic             clr_all,
   output ttp_pkg::rec_type rd_rec
);
   import ttp_pkg::*;

   rec_type              rec_mem_ff [NUM_TASKS];
   rec_type              raw_ff;
   logic                 raw_written_ff;
   logic                 raw_cleared_ff;
   logic [NUM_TASKS-1:0] written_ff, written_in;
   logic [NUM_TASKS-1:0] cleared_ff, cleared_in;
   rec_type              base;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         raw_ff         <= rec_mem_ff[rd_addr];
         raw_written_ff <= written_ff[rd_addr];
         raw_cleared_ff <= cleared_ff[rd_addr];
      end
   end

   always_comb begin
      written_in = written_ff;
      cleared_in = cleared_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
         cleared_in[wr_addr] = 1'b0;
      end
      if (clr_all) begin
         cleared_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         cleared_ff <= '0;
      end else begin
         written_ff <= written_in;
         cleared_ff <= cleared_in;
      end
   end

   // Unwritten entries read as the reset record; cleared ones as cleared stats.
   assign base   = raw_written_ff ? raw_ff : '0;
   assign rd_rec = raw_cleared_ff ? clear_rec(base) : base;

endmodule

// ----- src/ttp_alu.sv -----
// Two-stage record update: compares and differences, then min/max and totals.
`timescale 1ns / 1ps

module ttp_alu (
   input  logic             clock,
   input  logic             calc_ld,
   input  logic             is_run,
   input  logic             id_ok,
   input  logic             clr_now,
   input  ttp_pkg::rec_type rec,
   input  logic [63:0]      spacing_us,
   input  logic [63:0]      loop_time_us,
   input  logic [63:0]      start_time_us,
   input  logic [63:0]      stop_time_us,
   output ttp_pkg::rec_type new_rec,
   output logic             ran,
   output logic             frame_ok
);
   import ttp_pkg::*;

   logic        due_ff;
   logic        ok_ff;
   logic [63:0] period_ff;
   logic [63:0] dur_ff;
   logic [63:0] next_due_ff;
   rec_type     rec_ff;
   rec_type     upd;

   always_ff @(posedge clock) begin
      if (calc_ld) begin
         due_ff      <= is_run && id_ok && rec.enabled && (rec.next_due < loop_time_us);
         ok_ff       <= start_time_us < stop_time_us;
         period_ff   <= (rec.prev_start < start_time_us) ?
                        start_time_us - rec.prev_start : '0;
         dur_ff      <= (start_time_us < stop_time_us) ? stop_time_us - start_time_us : '0;
         next_due_ff <= loop_time_us + spacing_us;
         rec_ff      <= rec;
      end
   end

   always_comb begin
      upd            = rec_ff;
      upd.next_due   = next_due_ff;
      upd.count      = rec_ff.count + 32'd1;
      upd.prev_start = start_time_us;
      upd.seen       = 1'b1;
      if (rec_ff.seen) begin
         if (period_ff > rec_ff.per_max) upd.per_max = period_ff;
         if (period_ff < rec_ff.per_min) upd.per_min = period_ff;
      end
      upd.run_total = rec_ff.run_total + dur_ff;
      if (dur_ff < rec_ff.run_min) upd.run_min = dur_ff;
      if (dur_ff > rec_ff.run_max) upd.run_max = dur_ff;
   end

   assign new_rec  = due_ff ? upd : (clr_now ? clear_rec(rec_ff) : rec_ff);
   assign ran      = due_ff;
   assign frame_ok = due_ff && ok_ff;

endmodule

// ----- bench/task_timing_profiler_checker.sv -----
// Checker for the task timing profiler: predicts each result item and compares it.
`timescale 1ns / 1ps

module task_timing_profiler_checker #(
   parameter int NUM_TASKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [3:0]  req_task_id,
   input  logic [63:0] req_spacing_us,
   input  logic [63:0] req_loop_time_us,
   input  logic [63:0] req_start_time_us,
   input  logic [63:0] req_stop_time_us,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_ran,
   input  logic        rsp_frame_ok,
   input  logic [31:0] rsp_out_starts,
   input  logic [63:0] rsp_out_run_total,
   input  logic [63:0] rsp_out_run_min,
   input  logic [63:0] rsp_out_run_max,
   input  logic [63:0] rsp_out_period_min,
   input  logic [63:0] rsp_out_period_max,
   input  logic [63:0] rsp_grand_total,
   output int          fail_count,
   output int          pending
);

   import ttp_pkg::*;

   typedef struct {
      bit        enabled;
      bit [63:0] next_due;
      bit [63:0] prev_start;
      bit        seen;
      bit [31:0] starts;
      bit [63:0] total;
      bit [63:0] run_lo;
      bit [63:0] run_hi;
      bit [63:0] per_lo;
      bit [63:0] per_hi;
   } timing_rec_type;

   typedef struct {
      bit        ran;
      bit        frame_ok;
      bit [31:0] starts;
      bit [63:0] run_total;
      bit [63:0] run_min;
      bit [63:0] run_max;
      bit [63:0] period_min;
      bit [63:0] period_max;
      bit [63:0] grand_total;
   } profile_result_type;

   timing_rec_type     records [NUM_TASKS];
   profile_result_type expected_profiles [$];
   profile_result_type want;

   // Reset statistics of every record and enable it; schedule, last start and seen flag survive.
   function automatic void wipe_stats();
      for (int i = 0; i < NUM_TASKS; i++) begin
         records[i].enabled = 1'b1;
         records[i].starts  = '0;
         records[i].total   = '0;
         records[i].run_lo  = ALL_ONES;
         records[i].run_hi  = '0;
         records[i].per_lo  = ALL_ONES;
         records[i].per_hi  = '0;
      end
   endfunction

   function automatic profile_result_type predict_profile(op_type op, bit [3:0] id,
         bit [63:0] interval, bit [63:0] loop_t, bit [63:0] start, bit [63:0] stop);
      profile_result_type r;
      bit [63:0]          period;
      bit [63:0]          dur;
      bit [63:0]          sum;
      r = '{default: '0};
      case (op)
         OP_RUN: begin
            if (id < NUM_TASKS && records[id].enabled && records[id].next_due < loop_t) begin
               records[id].next_due = loop_t + interval;
               records[id].starts   = records[id].starts + 32'd1;
               period = (records[id].prev_start < start) ? start - records[id].prev_start : '0;
               records[id].prev_start = start;
               if (records[id].seen) begin
                  if (period > records[id].per_hi) records[id].per_hi = period;
                  if (period < records[id].per_lo) records[id].per_lo = period;
               end
               records[id].seen = 1'b1;
               dur = (start < stop) ? stop - start : '0;
               r.frame_ok = start < stop;
               records[id].total = records[id].total + dur;
               if (dur < records[id].run_lo) records[id].run_lo = dur;
               if (dur > records[id].run_hi) records[id].run_hi = dur;
               r.ran = 1'b1;
            end
         end
         OP_CLEAR: wipe_stats();
         OP_SUM: begin
            sum = '0;
            for (int i = 0; i < NUM_TASKS; i++) sum = sum + records[i].total;
            if (sum == '0) begin
               wipe_stats();
               sum = ALL_ONES;
            end
            r.grand_total = sum;
         end
         default: ;
      endcase
      if (id < NUM_TASKS) begin
         r.starts      = records[id].starts;
         r.run_total   = records[id].total;
         r.run_min     = records[id].run_lo;
         r.run_max     = records[id].run_hi;
         r.period_min  = records[id].per_lo;
         r.period_max  = records[id].per_hi;
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (records[i]) records[i] = '{default: '0};
         expected_profiles.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_profiles.size() == 0) begin
               $error("result item with no request outstanding");
               fail_count++;
            end else begin
               want = expected_profiles.pop_front();
               check_field("ran", 64'(want.ran), 64'(rsp_ran));
               check_field("frame_ok", 64'(want.frame_ok), 64'(rsp_frame_ok));
               check_field("out_starts", 64'(want.starts), 64'(rsp_out_starts));
               check_field("out_run_total", want.run_total, rsp_out_run_total);
               check_field("out_run_min", want.run_min, rsp_out_run_min);
               check_field("out_run_max", want.run_max, rsp_out_run_max);
               check_field("out_period_min", want.period_min, rsp_out_period_min);
               check_field("out_period_max", want.period_max, rsp_out_period_max);
               check_field("grand_total", want.grand_total, rsp_grand_total);
            end
         end
         if (req_valid && !req_stall)
            expected_profiles.push_back(predict_profile(op_type'(req_operation), req_task_id,
               req_spacing_us, req_loop_time_us, req_start_time_us, req_stop_time_us));
      end
      pending = expected_profiles.size();
   end

endmodule

// ----- bench/task_timing_profiler_tb.sv -----
// Testbench top of the task timing profiler: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module task_timing_profiler_tb;

   import ttp_pkg::*;

   localparam int NUM_TASKS      = 16;
   localparam int HOLD_CYCLES    = 300;   // receiver hold-off, long enough to back up the block
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving on either channel
   localparam int DRAIN_CYCLES   = 30;    // idle cycles before the verdict

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_READ;
   logic [3:0]  req_task_id = '0;
   logic [63:0] req_spacing_us = '0;
   logic [63:0] req_loop_time_us = '0;
   logic [63:0] req_start_time_us = '0;
   logic [63:0] req_stop_time_us = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ran;
   logic        rsp_frame_ok;
   logic [31:0] rsp_out_starts;
   logic [63:0] rsp_out_run_total;
   logic [63:0] rsp_out_run_min;
   logic [63:0] rsp_out_run_max;
   logic [63:0] rsp_out_period_min;
   logic [63:0] rsp_out_period_max;
   logic [63:0] rsp_grand_total;

   int          fail_count;
   int          pending;
   int          quiet_cycles = 0;
   int          hold_requests = 0;   // bumped by the stimulus to ask for a hold-off
   int          hold_served = 0;     // owned by the receiver process
   bit          send_gaps = 1'b1;    // sender inserts idle cycles
   bit          rsp_gaps = 1'b1;     // receiver stalls at random
   bit [63:0]   sched_time = 64'h0000_0400_0000_0000;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task_timing_profiler #(
      .NUM_TASKS(NUM_TASKS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_task_id         (req_task_id),
      .req_spacing_us      (req_spacing_us),
      .req_loop_time_us    (req_loop_time_us),
      .req_start_time_us   (req_start_time_us),
      .req_stop_time_us    (req_stop_time_us),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ran             (rsp_ran),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_out_starts      (rsp_out_starts),
      .rsp_out_run_total   (rsp_out_run_total),
      .rsp_out_run_min     (rsp_out_run_min),
      .rsp_out_run_max     (rsp_out_run_max),
      .rsp_out_period_min  (rsp_out_period_min),
      .rsp_out_period_max  (rsp_out_period_max),
      .rsp_grand_total     (rsp_grand_total)
   );

   task_timing_profiler_checker #(
      .NUM_TASKS(NUM_TASKS)
   ) i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_task_id         (req_task_id),
      .req_spacing_us      (req_spacing_us),
      .req_loop_time_us    (req_loop_time_us),
      .req_start_time_us   (req_start_time_us),
      .req_stop_time_us    (req_stop_time_us),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ran             (rsp_ran),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_out_starts      (rsp_out_starts),
      .rsp_out_run_total   (rsp_out_run_total),
      .rsp_out_run_min     (rsp_out_run_min),
      .rsp_out_run_max     (rsp_out_run_max),
      .rsp_out_period_min  (rsp_out_period_min),
      .rsp_out_period_max  (rsp_out_period_max),
      .rsp_grand_total     (rsp_grand_total),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   // Receiver: stall at random, or hold off for a long stretch when asked.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served++;
            rsp_stall <= 1'b1;
            // hold for the whole stretch, counted here
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= rsp_gaps && ($urandom_range(99) < 22);
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(op_type op, bit [3:0] id, bit [63:0] interval,
                            bit [63:0] loop_t, bit [63:0] start, bit [63:0] stop);
      // idle first, at random; valid stays high when no gap is drawn
      if (send_gaps) begin
         while ($urandom_range(99) < 22) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_task_id       <= id;
      req_spacing_us    <= interval;
      req_loop_time_us  <= loop_t;
      req_start_time_us <= start;
      req_stop_time_us  <= stop;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait until every outstanding result item has come back.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Mostly well-formed run attempts on an advancing schedule; the rest are
   // reads, clears, sums and fully random noise. A rare jump of the schedule
   // frees tasks that a noise item pushed far into the future.
   task automatic send_random_item();
      int        pick;
      bit [3:0]  id;
      bit [63:0] interval;
      bit [63:0] start;
      bit [63:0] stop;
      pick = int'($urandom_range(99));
      id   = 4'($urandom_range(NUM_TASKS - 1));
      if (pick < 70) begin
         sched_time = sched_time + 64'($urandom_range(1, 400));
         interval   = 64'($urandom_range(0, 600));
         start      = sched_time + 64'($urandom_range(0, 50));
         if ($urandom_range(9) == 0)
            stop = start - 64'($urandom_range(0, 20));   // zero or negative duration
         else
            stop = start + 64'($urandom_range(1, 300));
         send_item(OP_RUN, id, interval, sched_time, start, stop);
      end else if (pick < 82) begin
         send_item(OP_READ, id, rand64(), rand64(), rand64(), rand64());
      end else if (pick < 85) begin
         send_item(OP_CLEAR, id, rand64(), rand64(), rand64(), rand64());
      end else if (pick < 90) begin
         send_item(OP_SUM, id, rand64(), rand64(), rand64(), rand64());
      end else if (pick < 98) begin
         send_item(OP_RUN, id, rand64(), rand64(), rand64(), rand64());
      end else begin
         sched_time = rand64();
         send_item(OP_RUN, id, rand64(), sched_time, rand64(), rand64());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: tasks start disabled, so a run is ignored until a clear.
      send_item(OP_READ, 4'd0, '0, '0, '0, '0);
      send_item(OP_RUN, 4'd3, '0, 64'd5, 64'd1, 64'd2);
      // sum over all-zero totals clears and enables every task
      send_item(OP_SUM, 4'd3, '0, '0, '0, '0);
      send_item(OP_READ, 4'd3, '0, '0, '0, '0);
      // first start: no period yet
      send_item(OP_RUN, 4'd0, '0, 64'd1, 64'd10, 64'd20);
      // loop time equal to next due: not due
      send_item(OP_RUN, 4'd0, '0, 64'd1, 64'd30, 64'd40);
      // start not after previous start, stop equal to start
      send_item(OP_RUN, 4'd0, '0, 64'd2, 64'd5, 64'd5);
      // extremes: rescheduling wraps, stop before start
      send_item(OP_RUN, 4'd0, ALL_ONES, ALL_ONES, ALL_ONES, '0);
      send_item(OP_RUN, 4'd0, 64'd1, ALL_ONES, '0, ALL_ONES);
      // longest duration twice on the top task: the total wraps
      send_item(OP_RUN, 4'd15, '0, 64'd5, '0, ALL_ONES);
      send_item(OP_RUN, 4'd15, '0, 64'd6, '0, ALL_ONES);
      send_item(OP_READ, 4'd15, '0, '0, '0, '0);
      send_item(OP_SUM, 4'd15, '0, '0, '0, '0);
      send_item(OP_CLEAR, 4'd7, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      // two halves that wrap the summed totals to zero
      send_item(OP_RUN, 4'd1, '0, 64'h0000_0100_0000_0000, '0, 64'h8000_0000_0000_0000);
      send_item(OP_RUN, 4'd2, '0, 64'h0000_0100_0000_0000, '0, 64'h8000_0000_0000_0000);
      send_item(OP_SUM, 4'd1, '0, '0, '0, '0);
      send_item(OP_READ, 4'd1, '0, '0, '0, '0);
      send_item(OP_READ, 4'd15, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      // loop time zero is never due
      send_item(OP_RUN, 4'd0, '0, '0, '0, '0);

      // Random, both sides idling.
      repeat (600) send_random_item();

      // Hold off the receiver and keep offering items until the block backs up.
      hold_requests <= hold_requests + 1;
      send_gaps = 1'b0;
      repeat (12) send_random_item();
      send_gaps = 1'b1;

      // Pause the sender until everything is back.
      wait_all_results();

      // Long stretch at full rate on both sides.
      send_gaps = 1'b0;
      rsp_gaps  = 1'b0;
      repeat (500) send_random_item();
      send_gaps = 1'b1;
      rsp_gaps  = 1'b1;

      repeat (790) send_random_item();

      // Drain every result, then idle before the verdict.
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
